### design/smt_pkg.sv
// Shared types, codes and helpers for the SWIM membership table.
`default_nettype none

package smt_pkg;

   // Field widths and table sizing
   localparam int NODE_W        = 6;
   localparam int INC_W         = 32;
   localparam int NODE_RANGE    = 1 << NODE_W;
   localparam int NODES_DEFAULT = 64;
   localparam logic [INC_W-1:0] INC_MAX = '1;

   // Item operations
   typedef enum logic [2:0] {
      ACT_RELAY   = 3'd0,
      ACT_JOIN    = 3'd1,
      ACT_SUSPECT = 3'd2,
      ACT_CONFIRM = 3'd3,
      ACT_LEAVE   = 3'd4
   } action_type;

   // Gossip event types
   typedef enum logic [2:0] {
      EV_JOIN    = 3'd0,
      EV_ALIVE   = 3'd1,
      EV_SUSPECT = 3'd2,
      EV_DEAD    = 3'd3,
      EV_LEAVE   = 3'd4
   } gossip_event_type;

   // Peer states held in the table
   typedef enum logic [1:0] {
      ST_ALIVE   = 2'd0,
      ST_SUSPECT = 2'd1,
      ST_DEAD    = 2'd2,
      ST_LEFT    = 2'd3
   } peer_state_type;

   // Ring change notices
   typedef enum logic [1:0] {
      NT_NONE  = 2'd0,
      NT_ALIVE = 2'd1,
      NT_DEAD  = 2'd2,
      NT_LEFT  = 2'd3
   } notify_type;

   // One table entry as stored in the RAM
   typedef struct packed {
      peer_state_type   state;
      logic [INC_W-1:0] inc;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Input word
   typedef struct packed {
      logic [2:0]        action;
      logic [2:0]        event_type;
      logic [NODE_W-1:0] node;
      logic [INC_W-1:0]  incarnation;
   } req_word_type;

   // Result word
   typedef struct packed {
      logic              accepted;
      logic [1:0]        notify;
      logic [NODE_W-1:0] notify_node;
      logic              emit;
      logic [2:0]        emit_type;
      logic [NODE_W-1:0] emit_node;
      logic [INC_W-1:0]  emit_incarnation;
      logic [INC_W-1:0]  join_incarnation;
   } rsp_word_type;

   // Increment that sticks at the top incarnation
   function automatic logic [INC_W-1:0] inc_sat(input logic [INC_W-1:0] v);
      return (v == INC_MAX) ? INC_MAX : v + 32'd1;
   endfunction

endpackage

`default_nettype wire

### design/swim_membership_table.sv
// Top level of the SWIM membership table: entry RAM, update stage and result register.
//
//   port group  direction  handshake              payload
//   req_        in         req_valid / req_stall  req_data  (req_word_type)
//   rsp_        out        rsp_valid / rsp_stall  rsp_data  (rsp_word_type)
//   csr_        in         csr_write              csr_wdata (self node index)
//
// One word per cycle sustained while rsp_ is not stalled; a taken word is held in the update
// stage, and its result is then registered in the result register, from which it can leave.
// The rate is set by the read-modify-write of the entry RAM; a write to the entry that the
// following word reads is forwarded into that word's stage.
// Synchronous reset clears the valid bits, own incarnation, retired flag and self node;
// no clearing pass is needed. A stalled result holds the update stage, which stalls req_.
`default_nettype none

module swim_membership_table
   import smt_pkg::*;
#(
   parameter int NODES = NODES_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_stall,
   input  wire req_word_type      req_data,
   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   output      rsp_word_type      rsp_data,
   input  wire logic              csr_write,
   input  wire logic [NODE_W-1:0] csr_wdata
);

   // Only node indexes the field can carry need storage
   localparam int TBL_N  = (NODES < NODE_RANGE) ? NODES : NODE_RANGE;
   localparam int TBL_AW = $clog2(TBL_N);
   localparam logic [NODE_W:0] NODE_LIMIT = (NODE_W+1)'(TBL_N);

   // Registers
   logic [NODE_W-1:0] self_node_ff;
   logic [TBL_N-1:0]  valid_ff;
   logic [INC_W-1:0]  own_inc_ff,  own_inc_in;
   logic              own_retired_ff, own_retired_in;
   logic              s1_valid_ff, s1_valid_in;
   req_word_type      s1_ff;
   logic              fwd_ff, fwd_in;
   entry_type         fwd_entry_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_word_type      rsp_data_ff, rsp_data_in;

   // Handshake and stage control
   logic              req_accept;
   logic              s1_fire;
   logic [TBL_AW-1:0] req_idx, s1_idx;

   // RAM and update signals
   logic [ENTRY_W-1:0] ram_rdata;
   entry_type          ent;
   entry_type          wr_ent;
   logic               wr_en;
   logic               ent_wr;

   assign s1_fire    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_fire;
   assign req_accept = req_valid && !req_stall;
   assign req_idx    = TBL_AW'(req_data.node);
   assign s1_idx     = TBL_AW'(s1_ff.node);
   assign ent_wr     = s1_fire && wr_en;

   // Entry RAM: read when a word is taken, written back when it leaves the stage
   smt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TBL_N)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_wr),
      .wr_addr (s1_idx),
      .wr_data (wr_ent),
      .rd_en   (req_accept),
      .rd_addr (req_idx),
      .rd_data (ram_rdata)
   );

   // Forward a write-back to the same entry that the incoming word reads
   assign fwd_in = s1_fire && wr_en && (req_idx == s1_idx);
   assign ent    = fwd_ff ? fwd_entry_ff : entry_type'(ram_rdata);

   // Stage occupancy and result register
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // SWIM update rules on the entry, own incarnation and retired flag
   always_comb begin : update
      logic             is_self;
      logic             in_range;
      logic             v;
      peer_state_type   st;
      logic [INC_W-1:0] hi;
      logic [INC_W-1:0] inc;
      logic [INC_W-1:0] hi_bump;
      logic [INC_W-1:0] inc_bump;
      logic [INC_W-1:0] eff;
      logic             acc;
      notify_type       nt;
      logic             em;
      gossip_event_type emt;
      logic [INC_W-1:0] emi;
      logic [INC_W-1:0] ji;

      is_self  = (s1_ff.node == self_node_ff);
      in_range = {1'b0, s1_ff.node} < NODE_LIMIT;
      v        = in_range && valid_ff[s1_idx];
      st       = v ? ent.state : ST_ALIVE;
      hi       = v ? ent.inc : '0;
      inc      = s1_ff.incarnation;
      hi_bump  = inc_sat(hi);
      inc_bump = inc_sat(inc);
      eff      = (inc > hi_bump) ? inc : hi_bump;

      acc = 1'b0;
      nt  = NT_NONE;
      em  = 1'b0;
      emt = EV_JOIN;
      emi = '0;
      ji  = '0;
      wr_en  = 1'b0;
      wr_ent = '{state: st, inc: hi};
      own_inc_in     = own_inc_ff;
      own_retired_in = own_retired_ff;

      priority if (s1_ff.action == ACT_RELAY && is_self) begin
         // gossip about this node: leave retires, suspicion or death is refuted
         if (s1_ff.event_type == EV_LEAVE) begin
            if (!own_retired_ff) begin
               own_retired_in = 1'b1;
               acc = 1'b1;
               nt  = NT_LEFT;
            end
         end else if (s1_ff.event_type == EV_SUSPECT || s1_ff.event_type == EV_DEAD) begin
            if (inc >= own_inc_ff) begin
               own_inc_in = inc_bump;
               acc = 1'b1;
               em  = 1'b1;
               emt = EV_ALIVE;
               emi = inc_bump;
            end
         end
      end else if (s1_ff.action == ACT_JOIN && is_self) begin
         acc = 1'b1;
         ji  = own_inc_ff;
      end else if (s1_ff.action == ACT_LEAVE && is_self) begin
         if (!own_retired_ff) begin
            own_retired_in = 1'b1;
            acc = 1'b1;
            nt  = NT_LEFT;
            em  = 1'b1;
            emt = EV_LEAVE;
            emi = own_inc_ff;
         end
      end else if (in_range) begin
         unique case (s1_ff.action)
            ACT_RELAY: begin
               unique case (s1_ff.event_type)
                  EV_JOIN, EV_ALIVE: begin
                     if (!v || (st != ST_LEFT && inc > hi)) begin
                        wr_en  = 1'b1;
                        wr_ent = '{state: ST_ALIVE, inc: inc};
                        acc = 1'b1;
                        nt  = NT_ALIVE;
                     end
                  end
                  EV_SUSPECT: begin
                     if (v && inc >= hi && st != ST_DEAD && st != ST_LEFT &&
                         !(st == ST_SUSPECT && inc <= hi)) begin
                        wr_en  = 1'b1;
                        wr_ent = '{state: ST_SUSPECT, inc: inc};
                        acc = 1'b1;
                     end
                  end
                  EV_DEAD: begin
                     if (!v) begin
                        wr_en  = 1'b1;
                        wr_ent = '{state: ST_DEAD, inc: inc};
                        acc = 1'b1;
                     end else if (st != ST_DEAD && st != ST_LEFT && inc >= hi) begin
                        wr_en  = 1'b1;
                        wr_ent = '{state: ST_DEAD, inc: inc};
                        acc = 1'b1;
                        nt  = NT_DEAD;
                     end
                  end
                  EV_LEAVE: begin
                     // tombstone keeps the held incarnation of a held entry, else the offered one
                     if (!v) begin
                        wr_en  = 1'b1;
                        wr_ent = '{state: ST_LEFT, inc: inc};
                        acc = 1'b1;
                     end else if (st != ST_LEFT) begin
                        wr_en  = 1'b1;
                        wr_ent = '{state: ST_LEFT, inc: hi};
                        acc = 1'b1;
                        nt  = NT_LEFT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            ACT_JOIN: begin
               // grant the larger of the offered and the bumped held incarnation
               if (!v) begin
                  wr_en  = 1'b1;
                  wr_ent = '{state: ST_ALIVE, inc: inc};
                  acc = 1'b1;
                  nt  = NT_ALIVE;
                  ji  = inc;
               end else if (st != ST_LEFT) begin
                  wr_en  = 1'b1;
                  wr_ent = '{state: ST_ALIVE, inc: eff};
                  acc = 1'b1;
                  nt  = (st != ST_ALIVE) ? NT_ALIVE : NT_NONE;
                  ji  = eff;
               end
            end
            ACT_SUSPECT: begin
               if (v && st == ST_ALIVE) begin
                  wr_en  = 1'b1;
                  wr_ent = '{state: ST_SUSPECT, inc: hi};
                  acc = 1'b1;
                  em  = 1'b1;
                  emt = EV_SUSPECT;
                  emi = hi;
               end
            end
            ACT_CONFIRM: begin
               if (v && st != ST_DEAD && st != ST_LEFT) begin
                  wr_en  = 1'b1;
                  wr_ent = '{state: ST_DEAD, inc: hi};
                  acc = 1'b1;
                  nt  = NT_DEAD;
                  em  = 1'b1;
                  emt = EV_DEAD;
                  emi = hi;
               end
            end
            ACT_LEAVE: begin
               if (v && st != ST_LEFT) begin
                  wr_en  = 1'b1;
                  wr_ent = '{state: ST_LEFT, inc: hi};
                  acc = 1'b1;
                  nt  = NT_LEFT;
                  em  = 1'b1;
                  emt = EV_LEAVE;
                  emi = hi;
               end
            end
            default: begin
            end
         endcase
      end else begin
         // node beyond the table: no effect
      end

      // result word; unused fields read zero
      rsp_data_in.accepted         = acc;
      rsp_data_in.notify           = nt;
      rsp_data_in.notify_node      = (nt != NT_NONE) ? s1_ff.node : '0;
      rsp_data_in.emit             = em;
      rsp_data_in.emit_type        = emt;
      rsp_data_in.emit_node        = em ? s1_ff.node : '0;
      rsp_data_in.emit_incarnation = emi;
      rsp_data_in.join_incarnation = ji;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         self_node_ff   <= '0;
         valid_ff       <= '0;
         own_inc_ff     <= '0;
         own_retired_ff <= 1'b0;
         s1_valid_ff    <= 1'b0;
         fwd_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write) begin
            self_node_ff <= csr_wdata;
         end
         if (ent_wr) begin
            valid_ff[s1_idx] <= 1'b1;
         end
         if (s1_fire) begin
            own_inc_ff     <= own_inc_in;
            own_retired_ff <= own_retired_in;
         end
         if (req_accept) begin
            fwd_ff <= fwd_in;
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ff        <= req_data;
         fwd_entry_ff <= wr_ent;
      end
      if (s1_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A ring notice only accompanies an accepted word
   a_notify_acc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.notify != NT_NONE |-> rsp_data.accepted)
      else $error("notice without acceptance");

   // No queued event means all its fields are zero
   a_emit_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.emit |->
         rsp_data.emit_type == '0 && rsp_data.emit_node == '0 &&
         rsp_data.emit_incarnation == '0)
      else $error("event fields set without emit");

   // Own incarnation never goes backwards
   a_own_inc_mono: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> own_inc_ff >= $past(own_inc_ff))
      else $error("own incarnation decreased");

   // Once retired, the node stays retired
   a_retired_sticky: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $past(own_retired_ff) |-> own_retired_ff)
      else $error("retired flag cleared");

endmodule

`default_nettype wire

### design/smt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module smt_ram
   import smt_pkg::*;
#(
   parameter int WIDTH = ENTRY_W,
   parameter int DEPTH = NODES_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
